[hdl/pee_pkg.sv]
// ----------------------------------------------------------------------------
// pee_pkg
// Shared widths, character codes and status codes of the postfix evaluator.
// ----------------------------------------------------------------------------
package pee_pkg;

  localparam int unsigned WORD_W   = 32;
  localparam int unsigned CHAR_W   = 8;
  localparam int unsigned STATUS_W = 3;

  typedef logic [WORD_W-1:0]   word_t;
  typedef logic [CHAR_W-1:0]   char_t;
  typedef logic [STATUS_W-1:0] status_t;

  localparam status_t ST_OK      = 3'd0;
  localparam status_t ST_UNDER   = 3'd1;
  localparam status_t ST_OVER    = 3'd2;
  localparam status_t ST_INVALID = 3'd3;
  localparam status_t ST_DIVZERO = 3'd4;

  localparam char_t CHAR_ZERO  = 8'h30;
  localparam char_t CHAR_NINE  = 8'h39;
  localparam char_t CHAR_SPACE = 8'h20;
  localparam char_t CHAR_TAB   = 8'h09;
  localparam char_t CHAR_CR    = 8'h0D;
  localparam char_t CHAR_PLUS  = 8'h2B;
  localparam char_t CHAR_MINUS = 8'h2D;
  localparam char_t CHAR_STAR  = 8'h2A;
  localparam char_t CHAR_SLASH = 8'h2F;

  function automatic logic is_digit(char_t c);
    return (c >= CHAR_ZERO) && (c <= CHAR_NINE);
  endfunction

  function automatic logic is_space(char_t c);
    return (c == CHAR_SPACE) || ((c >= CHAR_TAB) && (c <= CHAR_CR));
  endfunction

endpackage

[hdl/pee_ram.sv]
// ----------------------------------------------------------------------------
// pee_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module pee_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    // read data holds until the next read
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[hdl/pee_div.sv]
// ----------------------------------------------------------------------------
// pee_div
// Signed 32-bit truncating divider, restoring, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pee_div (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  pee_pkg::word_t dividend_i,
  input  pee_pkg::word_t divisor_i,
  output logic          done_o,
  output pee_pkg::word_t quotient_o
);
  import pee_pkg::*;

  localparam int unsigned CNT_W = $clog2(WORD_W + 1);

  word_t            rem_q, rem_d;
  word_t            quo_q, quo_d;
  word_t            den_q, den_d;
  logic             neg_q, neg_d;
  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  logic [WORD_W:0]  shifted;
  logic [WORD_W:0]  trial;

  assign shifted = {rem_q, quo_q[WORD_W-1]};
  assign trial   = shifted - {1'b0, den_q};

  always_comb begin
    rem_d  = rem_q;
    quo_d  = quo_q;
    den_d  = den_q;
    neg_d  = neg_q;
    busy_d = busy_q;
    cnt_d  = cnt_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d  = '0;
      quo_d  = dividend_i[WORD_W-1] ? word_t'(-dividend_i) : dividend_i;
      den_d  = divisor_i[WORD_W-1] ? word_t'(-divisor_i) : divisor_i;
      neg_d  = dividend_i[WORD_W-1] ^ divisor_i[WORD_W-1];
      busy_d = 1'b1;
      cnt_d  = CNT_W'(WORD_W);
    end else if (busy_q) begin
      // no borrow: the divisor fits, take the difference
      if (!trial[WORD_W]) begin
        rem_d = trial[WORD_W-1:0];
        quo_d = {quo_q[WORD_W-2:0], 1'b1};
      end else begin
        rem_d = shifted[WORD_W-1:0];
        quo_d = {quo_q[WORD_W-2:0], 1'b0};
      end
      cnt_d = cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    den_q <= den_d;
    neg_q <= neg_d;
  end

  assign done_o     = done_q;
  assign quotient_o = neg_q ? word_t'(-quo_q) : quo_q;

endmodule

[hdl/postfix_expression_evaluator.sv]
// ----------------------------------------------------------------------------
// postfix_expression_evaluator
// Postfix expression evaluator fed one character per item; operand stack
// kept in a synchronous RAM.
// ----------------------------------------------------------------------------
//  channel  | handshake              | payload
//  ---------+------------------------+-------------------------------------
//  in       | in_valid_i/in_ready_o   | character_i, end_of_expression_i
//  out      | out_valid_o/out_ready_i | value_o, status_o
//
// Digit: accepted alone. Space: accepted alone, plus a push when a number is pending.
// + - *: accept, two pops, execute, push; a pending number adds a push first.
// /: the push waits on the one-bit-per-cycle divider; not on a zero divisor.
// End mark adds a final pop and a result load (only the load once abandoned);
// the load stalls while the previous result still waits in the output register.
// Reset clears pointer and flags, not the stack RAM.
module postfix_expression_evaluator #(
  parameter int unsigned STACK_DEPTH = 128
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  pee_pkg::char_t         character_i,
  input  logic                   end_of_expression_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic signed [31:0]     value_o,
  output pee_pkg::status_t       status_o
);
  import pee_pkg::*;

  localparam int unsigned AW  = $clog2(STACK_DEPTH);
  localparam int unsigned SPW = $clog2(STACK_DEPTH + 1);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_PUSHN = 4'd1;
  localparam logic [3:0] S_POPR  = 4'd2;
  localparam logic [3:0] S_POPL  = 4'd3;
  localparam logic [3:0] S_OPER  = 4'd4;
  localparam logic [3:0] S_DIV   = 4'd5;
  localparam logic [3:0] S_PUSHR = 4'd6;
  localparam logic [3:0] S_POPF  = 4'd7;
  localparam logic [3:0] S_FIN   = 4'd8;

  logic [3:0]     state_q, state_d;
  logic [SPW-1:0] sp_q, sp_d;
  word_t          acc_q, acc_d;
  logic           innum_q, innum_d;
  status_t        sticky_q, sticky_d;
  logic           aband_q, aband_d;
  logic           hit_q, hit_d;
  char_t          c_q, c_d;
  logic           last_q, last_d;
  word_t          right_q, right_d;
  word_t          res_q, res_d;
  logic           outv_q, outv_d;
  word_t          oval_q, oval_d;
  status_t        ostat_q, ostat_d;

  logic           push_req;
  word_t          push_val;
  logic           pop_req;
  status_t        flag_code;
  logic           ram_we;
  logic           ram_re;
  logic [SPW-1:0] sp_dec;
  word_t          rdata;
  word_t          popped;
  logic           div_start;
  logic           div_done;
  word_t          div_quo;

  assign sp_dec = sp_q - SPW'(1);
  assign popped = hit_q ? rdata : '1;

  always_comb begin
    state_d   = state_q;
    sp_d      = sp_q;
    acc_d     = acc_q;
    innum_d   = innum_q;
    sticky_d  = sticky_q;
    aband_d   = aband_q;
    hit_d     = hit_q;
    c_d       = c_q;
    last_d    = last_q;
    right_d   = right_q;
    res_d     = res_q;
    outv_d    = outv_q && !out_ready_i;
    oval_d    = oval_q;
    ostat_d   = ostat_q;
    push_req  = 1'b0;
    push_val  = acc_q;
    pop_req   = 1'b0;
    flag_code = ST_OK;
    div_start = 1'b0;
    ram_we    = 1'b0;
    ram_re    = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          c_d    = character_i;
          last_d = end_of_expression_i;
          if (aband_q) begin
            if (end_of_expression_i) begin
              hit_d   = 1'b0;
              state_d = S_FIN;
            end
          end else if (is_digit(character_i)) begin
            acc_d   = (acc_q << 3) + (acc_q << 1) + word_t'(character_i[3:0]);
            innum_d = 1'b1;
            if (end_of_expression_i) begin
              state_d = S_PUSHN;
            end
          end else if (innum_q) begin
            state_d = S_PUSHN;
          end else if (is_space(character_i)) begin
            if (end_of_expression_i) begin
              state_d = S_POPF;
            end
          end else begin
            state_d = S_POPR;
          end
        end
      end
      S_PUSHN: begin
        push_req = 1'b1;
        push_val = acc_q;
        acc_d    = '0;
        innum_d  = 1'b0;
        if (!is_digit(c_q) && !is_space(c_q)) begin
          state_d = S_POPR;
        end else if (last_q) begin
          state_d = S_POPF;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_POPR: begin
        pop_req = 1'b1;
        state_d = S_POPL;
      end
      S_POPL: begin
        right_d = popped;
        pop_req = 1'b1;
        state_d = S_OPER;
      end
      S_OPER: begin
        state_d = S_PUSHR;
        unique case (c_q)
          CHAR_PLUS:  res_d = popped + right_q;
          CHAR_MINUS: res_d = popped - right_q;
          CHAR_STAR:  res_d = popped * right_q;
          CHAR_SLASH: begin
            if (right_q == '0) begin
              flag_code = ST_DIVZERO;
              res_d     = '0;
            end else begin
              div_start = 1'b1;
              state_d   = S_DIV;
            end
          end
          default: begin
            // invalid operator: rest of the expression is skipped
            flag_code = ST_INVALID;
            aband_d   = 1'b1;
            if (last_q) begin
              hit_d   = 1'b0;
              state_d = S_FIN;
            end else begin
              state_d = S_IDLE;
            end
          end
        endcase
      end
      S_DIV: begin
        if (div_done) begin
          res_d   = div_quo;
          state_d = S_PUSHR;
        end
      end
      S_PUSHR: begin
        push_req = 1'b1;
        push_val = res_q;
        state_d  = last_q ? S_POPF : S_IDLE;
      end
      S_POPF: begin
        pop_req = 1'b1;
        state_d = S_FIN;
      end
      S_FIN: begin
        if (!outv_q || out_ready_i) begin
          outv_d   = 1'b1;
          oval_d   = popped;
          ostat_d  = sticky_q;
          sp_d     = '0;
          acc_d    = '0;
          innum_d  = 1'b0;
          sticky_d = ST_OK;
          aband_d  = 1'b0;
          hit_d    = 1'b0;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (push_req) begin
      if (sp_q == SPW'(STACK_DEPTH)) begin
        flag_code = ST_OVER;
      end else begin
        ram_we = 1'b1;
        sp_d   = sp_q + SPW'(1);
      end
    end
    if (pop_req) begin
      if (sp_q == '0) begin
        flag_code = ST_UNDER;
        hit_d     = 1'b0;
      end else begin
        ram_re = 1'b1;
        sp_d   = sp_dec;
        hit_d  = 1'b1;
      end
    end
    // first error sticks
    if ((flag_code != ST_OK) && (sticky_q == ST_OK)) begin
      sticky_d = flag_code;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      sp_q     <= '0;
      acc_q    <= '0;
      innum_q  <= 1'b0;
      sticky_q <= ST_OK;
      aband_q  <= 1'b0;
      hit_q    <= 1'b0;
      outv_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      sp_q     <= sp_d;
      acc_q    <= acc_d;
      innum_q  <= innum_d;
      sticky_q <= sticky_d;
      aband_q  <= aband_d;
      hit_q    <= hit_d;
      outv_q   <= outv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    c_q     <= c_d;
    last_q  <= last_d;
    right_q <= right_d;
    res_q   <= res_d;
    oval_q  <= oval_d;
    ostat_q <= ostat_d;
  end

  pee_ram #(
    .WIDTH (WORD_W),
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (sp_q[AW-1:0]),
    .wdata_i (push_val),
    .re_i    (ram_re),
    .raddr_i (sp_dec[AW-1:0]),
    .rdata_o (rdata)
  );

  pee_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (popped),
    .divisor_i  (right_q),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = outv_q;
  assign value_o     = oval_q;
  assign status_o    = ostat_q;

endmodule

[tb/pee_result_monitor.sv]
// ----------------------------------------------------------------------------
// pee_result_monitor
// Watches both channels of the postfix evaluator. It mirrors the evaluation
// of every accepted character in its own stack model, and compares each
// result item with the oldest predicted one.
// ----------------------------------------------------------------------------
module pee_result_monitor #(
  parameter int unsigned STACK_DEPTH = 128
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  pee_pkg::char_t     character_i,
  input  logic               end_of_expression_i,
  input  logic               out_valid_i,
  input  logic               out_ready_i,
  input  logic signed [31:0] value_i,
  input  pee_pkg::status_t   status_i,
  output int                 mismatch_cnt_o,
  output int                 pending_o
);
  import pee_pkg::*;

  typedef struct packed {
    word_t   value;
    status_t status;
  } rpn_result_t;

  rpn_result_t pending_results[$];
  rpn_result_t oldest;

  // mirrored evaluator state
  word_t       stk[STACK_DEPTH];
  int unsigned depth     = 0;
  word_t       acc       = '0;
  bit          in_num    = 1'b0;
  bit          abandoned = 1'b0;
  status_t     sticky    = ST_OK;

  int errs      = 0;
  int n_pending = 0;

  assign mismatch_cnt_o = errs;
  assign pending_o      = n_pending;

  // only the first error of an expression is kept
  function automatic void raise(status_t code);
    if (sticky == ST_OK) sticky = code;
  endfunction

  function automatic void push_word(word_t w);
    if (depth >= STACK_DEPTH) begin
      raise(ST_OVER);
    end else begin
      stk[depth] = w;
      depth++;
    end
  endfunction

  function automatic word_t pop_word();
    if (depth == 0) begin
      raise(ST_UNDER);
      return '1;
    end
    depth--;
    return stk[depth];
  endfunction

  task automatic evaluate_char(char_t c, logic last);
    word_t       rhs;
    word_t       lhs;
    word_t       res;
    longint      quo;
    bit          valid_op;
    rpn_result_t r;
    if (!abandoned) begin
      if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
        acc    = acc * 32'd10 + word_t'(c - CHAR_ZERO);
        in_num = 1'b1;
      end else begin
        if (in_num) begin
          push_word(acc);
          acc    = '0;
          in_num = 1'b0;
        end
        if (!(c == CHAR_SPACE || (c >= CHAR_TAB && c <= CHAR_CR))) begin
          // both pops happen even for an invalid operator
          rhs      = pop_word();
          lhs      = pop_word();
          valid_op = 1'b1;
          res      = '0;
          case (c)
            CHAR_PLUS:  res = lhs + rhs;
            CHAR_MINUS: res = lhs - rhs;
            CHAR_STAR:  res = lhs * rhs;
            CHAR_SLASH: begin
              if (rhs == '0) begin
                raise(ST_DIVZERO);
              end else begin
                // 64-bit quotient so most negative over minus one wraps
                quo = longint'($signed(lhs)) / longint'($signed(rhs));
                res = quo[31:0];
              end
            end
            default: begin
              raise(ST_INVALID);
              abandoned = 1'b1;
              valid_op  = 1'b0;
            end
          endcase
          if (valid_op) push_word(res);
        end
      end
    end
    if (last) begin
      if (abandoned) begin
        r.value = '1;
      end else begin
        if (in_num) push_word(acc);
        r.value = pop_word();
      end
      r.status = sticky;
      pending_results.push_back(r);
      depth     = 0;
      acc       = '0;
      in_num    = 1'b0;
      abandoned = 1'b0;
      sticky    = ST_OK;
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_i && out_ready_i) begin
        if (pending_results.size() == 0) begin
          $display("%0t: unexpected result item value %h status %0d",
                   $time, value_i, status_i);
          errs++;
        end else begin
          oldest = pending_results.pop_front();
          if (value_i !== oldest.value) begin
            $display("%0t: value mismatch, expected %h actual %h",
                     $time, oldest.value, value_i);
            errs++;
          end
          if (status_i !== oldest.status) begin
            $display("%0t: status mismatch, expected %0d actual %0d",
                     $time, oldest.status, status_i);
            errs++;
          end
        end
      end
      if (in_valid_i && in_ready_i) evaluate_char(character_i, end_of_expression_i);
      n_pending = pending_results.size();
    end
  end

endmodule

[tb/tb_postfix_expression_evaluator.sv]
// ----------------------------------------------------------------------------
// tb_postfix_expression_evaluator
// Feeds the postfix evaluator with directed expressions, then random ones:
// mostly well-formed with random operands, plus broken ones, noise bytes,
// division corner cases and deep stacks. Both sides idle at random.
// ----------------------------------------------------------------------------
module tb_postfix_expression_evaluator;
  import pee_pkg::*;

  localparam int unsigned STACK_DEPTH  = 128;
  localparam int          RANDOM_ITEMS = 1450;
  localparam int          IDLE_PCT     = 19;
  localparam int          HOLD_CYCLES  = 300;
  localparam int          DRAIN_CYCLES = 60;
  localparam char_t       CHAR_NUL     = 8'h00;
  localparam char_t       CHAR_TOP     = 8'hFF;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_ready_o;
  char_t              character_i;
  logic               end_of_expression_i;
  logic               out_valid_o;
  logic               out_ready_i;
  logic signed [31:0] value_o;
  status_t            status_o;

  int mismatch_cnt;
  int pending_cnt;

  bit    calm     = 1'b0;
  bit    hold_req = 1'b0;
  int    sent_items = 0;
  char_t expr_q[$];

  postfix_expression_evaluator #(
    .STACK_DEPTH(STACK_DEPTH)
  ) u_dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .character_i        (character_i),
    .end_of_expression_i(end_of_expression_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .value_o            (value_o),
    .status_o           (status_o)
  );

  pee_result_monitor #(
    .STACK_DEPTH(STACK_DEPTH)
  ) u_monitor (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_ready_i         (in_ready_o),
    .character_i        (character_i),
    .end_of_expression_i(end_of_expression_i),
    .out_valid_i        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .value_i            (value_o),
    .status_i           (status_o),
    .mismatch_cnt_o     (mismatch_cnt),
    .pending_o          (pending_cnt)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // result side: random stalls, one long hold-off on request
  initial begin
    bit held;
    held        = 1'b0;
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req && !held) begin
        held        = 1'b1;
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
      end else begin
        out_ready_i <= calm || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  initial begin
    #5_000_000;
    $display("timeout at %0t", $time);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  task automatic send_item(char_t c, logic last);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i          <= 1'b1;
    character_i         <= c;
    end_of_expression_i <= last;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    @(negedge clk_i);
    sent_items++;
  endtask

  // last character of the buffer carries the end mark
  task automatic send_expr();
    foreach (expr_q[i]) send_item(expr_q[i], i == expr_q.size() - 1);
    expr_q.delete();
  endtask

  task automatic add_str(string s);
    for (int i = 0; i < s.len(); i++) expr_q.push_back(char_t'(s[i]));
  endtask

  task automatic add_ws();
    int k;
    k = $urandom_range(5);
    expr_q.push_back(k == 5 ? CHAR_SPACE : char_t'(CHAR_TAB + k));
  endtask

  // mostly short numbers; ten digits make the accumulator wrap
  task automatic add_number();
    int r;
    int ndig;
    r    = $urandom_range(99);
    ndig = (r < 55) ? 1 : (r < 80) ? 2 : (r < 92) ? 4 : 10;
    repeat (ndig) expr_q.push_back(char_t'(CHAR_ZERO + $urandom_range(9)));
  endtask

  function automatic char_t pick_op();
    case ($urandom_range(3))
      0:       return CHAR_PLUS;
      1:       return CHAR_MINUS;
      2:       return CHAR_STAR;
      default: return CHAR_SLASH;
    endcase
  endfunction

  task automatic build_wellformed(int operands);
    int depth;
    int left;
    bit after_num;
    depth     = 0;
    left      = operands;
    after_num = 1'b0;
    if ($urandom_range(9) == 0) add_ws();
    while (left > 0 || depth > 1) begin
      if (depth >= 2 && (left == 0 || $urandom_range(1) == 1)) begin
        if ($urandom_range(2) == 0) add_ws();
        expr_q.push_back(pick_op());
        depth--;
        after_num = 1'b0;
      end else begin
        // adjacent numbers need a separator
        if (after_num || $urandom_range(2) == 0) add_ws();
        add_number();
        depth++;
        left--;
        after_num = 1'b1;
      end
    end
    if ($urandom_range(5) == 0) add_ws();
  endtask

  initial begin
    int expr_idx;
    int kind;
    int base;
    in_valid_i          = 1'b0;
    character_i         = CHAR_NUL;
    end_of_expression_i = 1'b0;
    rst_ni              = 1'b0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed: each operator, pop from empty, divide by zero,
    // invalid operator and NUL, end on a digit, whitespace kinds
    add_str("12\t5/");
    send_expr();
    add_str("3 4+2*");
    send_expr();
    add_str("1 9-");
    send_expr();
    add_str("+");
    send_expr();
    add_str("5\n0/");
    send_expr();
    add_str("1");
    expr_q.push_back(CHAR_TOP);
    send_expr();
    expr_q.push_back(CHAR_NUL);
    send_expr();
    add_str("7 42");
    send_expr();

    base     = sent_items;
    expr_idx = 0;
    while (sent_items - base < RANDOM_ITEMS) begin
      calm = (expr_idx >= 60 && expr_idx < 85);
      if (expr_idx == 25) hold_req = 1'b1;
      if (expr_idx == 50) begin
        in_valid_i <= 1'b0;
        while (pending_cnt != 0) @(negedge clk_i);
        @(negedge clk_i);
      end
      kind = $urandom_range(99);
      if (expr_idx % 60 == 30) begin
        // deep stack: fills up, sometimes past full
        repeat ($urandom_range(126, 131)) begin
          add_number();
          add_ws();
        end
        repeat ($urandom_range(3)) expr_q.push_back(pick_op());
      end else if (kind < 70) begin
        build_wellformed($urandom_range(1, 6));
      end else if (kind < 85) begin
        build_wellformed($urandom_range(1, 5));
        if ($urandom_range(1) == 0)
          expr_q.insert($urandom_range(expr_q.size() - 1), char_t'($urandom_range(255)));
        else
          expr_q.push_front(pick_op());
      end else if (kind < 92) begin
        repeat ($urandom_range(1, 8)) expr_q.push_back(char_t'($urandom_range(255)));
      end else begin
        case ($urandom_range(2))
          0: add_str("2147483648 0 1-/");
          1: begin
            add_number();
            add_str(" 0/");
          end
          default: begin
            add_str("-2147483647 2 ");
            expr_q.push_back(CHAR_SLASH);
          end
        endcase
      end
      send_expr();
      expr_idx++;
    end
    in_valid_i <= 1'b0;

    while (pending_cnt != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_cnt == 0 && pending_cnt == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
